// ----- src/xcd_pkg.sv -----
// Package for the x86 call address decoder: queue entry type, kind codes and
// filter constants. No dependencies; all files but xcd_if.sv import it.
`default_nettype none

package xcd_pkg;

  localparam int unsigned WinBytes  = 8;
  localparam int unsigned FillW     = $clog2(WinBytes + 1);
  localparam int unsigned IdxW      = $clog2(WinBytes);
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] SkipReset  = 32'd5;
  localparam logic [31:0] OpSpan     = 32'd4;
  localparam logic [6:0]  CallOpTop  = 7'h74;
  localparam logic [31:0] BiasAdd    = 32'h0100_0000;
  localparam logic [7:0]  TopOnes    = 8'hFF;
  localparam logic [7:0]  TopZeros   = 8'h00;

  typedef enum logic {
    KIND_BYTE,
    KIND_END
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic [8*WinBytes-1:0]   window;
    logic [FillW-1:0]        fill;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- src/xcd_if.sv -----
// Stream interfaces of the x86 call address decoder: input and result words.
// Carry valid, ready and payload; no package dependency.
`default_nettype none

interface xcd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface xcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       last;

  modport source (output valid, output out_byte, output out_valid, output last, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input last, output ready);
endinterface

`default_nettype wire

// ----- src/xcd_front.sv -----
// Front end: holds the delay window, position and skip mark, restores call
// operands and pushes byte or drain entries. Depends on xcd_pkg and xcd_if.
`default_nettype none

module xcd_front import xcd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  xcd_in_if.sink     data_in_i,
  output q_entry_t   push_entry_o,
  output logic       push_o,
  input  wire logic  push_ready_i
);

  logic [8*WinBytes-1:0] win_q, win_d;
  logic [31:0]           pos_q, pos_d;
  logic [31:0]           skip_q, skip_d;
  logic [FillW-1:0]      fill_q, fill_d;

  logic [31:0] older, newer, x_off, newer_fix;
  logic [24:0] swapped, restored;
  logic        hit, fits, accept;
  logic [8*WinBytes-1:0] win_fix;

  assign data_in_i.ready = push_ready_i;
  assign accept = data_in_i.valid && push_ready_i;

  always_comb begin
    older    = win_q[31:0];
    newer    = win_q[63:32];
    hit      = (pos_q >= skip_q) && (older[31:25] == CallOpTop);
    x_off    = newer + BiasAdd;
    fits     = (x_off[31:25] == 7'd0);
    swapped  = {x_off[7:0], x_off[15:8], x_off[23:16], x_off[24]};
    restored = swapped - pos_q[24:0];
    newer_fix = {(restored[24] ? TopZeros : TopOnes), restored[23:0]};
    win_fix  = (hit && fits) ? {newer_fix, older} : win_q;
  end

  always_comb begin
    win_d  = win_q;
    pos_d  = pos_q;
    skip_d = skip_q;
    fill_d = fill_q;
    push_o = 1'b0;
    push_entry_o.kind   = KIND_BYTE;
    push_entry_o.window = win_fix;
    push_entry_o.fill   = fill_q;
    if (accept) begin
      if (data_in_i.action) begin
        push_o              = 1'b1;
        push_entry_o.kind   = KIND_END;
        push_entry_o.window = win_q;
        win_d  = '0;
        pos_d  = '0;
        skip_d = SkipReset;
        fill_d = '0;
      end else begin
        push_o = (fill_q == FillW'(WinBytes));
        if (hit) begin
          skip_d = pos_q + OpSpan;
        end
        win_d = {data_in_i.in_byte, win_fix[8*WinBytes-1:8]};
        pos_d = pos_q + 32'd1;
        if (fill_q != FillW'(WinBytes)) begin
          fill_d = fill_q + FillW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pos_q  <= '0;
      skip_q <= SkipReset;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      pos_q  <= pos_d;
      skip_q <= skip_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/xcd_queue.sv -----
// Two-entry queue between the front and back ends of the decoder.
// Depends on xcd_pkg for the entry type and depth.
`default_nettype none

module xcd_queue import xcd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire q_entry_t push_entry_i,
  input  wire logic     push_i,
  output logic          push_ready_o,
  output q_entry_t      head_o,
  output logic          head_valid_o,
  input  wire logic     pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  q_entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/xcd_back.sv -----
// Back end: turns queue entries into result words via an output register,
// draining an end entry one byte per cycle unless it stalls. Uses xcd_pkg.
`default_nettype none

module xcd_back import xcd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire q_entry_t head_i,
  input  wire logic     head_valid_i,
  output logic          pop_o,
  xcd_out_if.source     data_out_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            ov_q;
  logic [7:0]      byte_q, e_byte;
  logic            vld_q, e_vld;
  logic            last_q, e_last;
  logic            emit, load_ok;
  logic [IdxW-1:0] sel;

  assign load_ok = !ov_q || data_out_o.ready;
  assign sel     = idx_q - head_i.fill[IdxW-1:0];

  always_comb begin
    pop_o  = 1'b0;
    emit   = 1'b0;
    e_byte = head_i.window[7:0];
    e_vld  = 1'b1;
    e_last = 1'b0;
    idx_d  = idx_q;
    if (head_valid_i && load_ok) begin
      emit = 1'b1;
      unique case (head_i.kind)
        KIND_BYTE: begin
          pop_o = 1'b1;
        end
        KIND_END: begin
          if (head_i.fill == '0) begin
            e_byte = 8'd0;
            e_vld  = 1'b0;
            e_last = 1'b1;
            pop_o  = 1'b1;
          end else begin
            e_byte = head_i.window[8*sel +: 8];
            e_last = ({1'b0, idx_q} == head_i.fill - FillW'(1));
            if (e_last) begin
              pop_o = 1'b1;
              idx_d = '0;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= e_byte;
      vld_q  <= e_vld;
      last_q <= e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (data_out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign data_out_o.valid     = ov_q;
  assign data_out_o.out_byte  = byte_q;
  assign data_out_o.out_valid = vld_q;
  assign data_out_o.last      = last_q;

endmodule

`default_nettype wire

// ----- src/x86_call_address_decoder.sv -----
// Channel     | Dir | Payload                          | Handshake
// data_in_i   | in  | action, in_byte                  | valid / ready
// data_out_o  | out | out_byte, out_valid, last        | valid / ready
//
// A data word is taken every cycle while the queue has room; it yields a result word
// once eight bytes are held. An end word yields one result word per buffered byte,
// one per cycle while the output is ready and at least one, paced by the back end's
// drain counter; the front end keeps taking words until the two-entry queue fills.
// Reset is asynchronous and active low; it clears window and position and sets the
// skip mark to five.
// A two-entry queue and an output register decouple input stalls from output stalls.
`default_nettype none

module x86_call_address_decoder import xcd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xcd_in_if.sink    data_in_i,
  xcd_out_if.source data_out_o
);

  q_entry_t push_entry, head;
  logic     push, push_ready, head_valid, pop;

  xcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_in_i    (data_in_i),
    .push_entry_o (push_entry),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  xcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_entry_i (push_entry),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  xcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .data_out_o   (data_out_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the x86 call address decoder: drives data and end
// words, predicts restored bytes in a scoreboard class and checks every result word.
// Depends on xcd_pkg and the xcd_in_if / xcd_out_if interfaces.
`default_nettype none

module tb_top;
  import xcd_pkg::*;

  localparam int unsigned HoldLen   = 80;
  localparam int unsigned PhaseLen  = 84;
  localparam logic [31:0] OpTopMask = 32'hFE00_0000;
  localparam logic [31:0] OpTopCall = 32'hE800_0000;
  localparam logic [31:0] OpBias    = 32'hFF00_0000;
  localparam logic [31:0] OpRange   = 32'h0200_0000;
  localparam logic [31:0] OpMask    = 32'h01FF_FFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } restored_t;

  class restore_board;
    logic [63:0] window;
    logic [31:0] position;
    logic [31:0] skip_mark;
    logic [7:0]  empty_marks;
    restored_t   restored_q[$];
    int          mismatches;
    int          words_checked;
    int          ends_seen;
    int          operands_restored;

    function new();
      mismatches        = 0;
      words_checked     = 0;
      ends_seen         = 0;
      operands_restored = 0;
      clear();
    endfunction

    function void clear();
      window      = '0;
      position    = '0;
      skip_mark   = 32'd5;
      empty_marks = 8'hFF;
    endfunction

    function logic [31:0] swap_operand(logic [31:0] v);
      logic [31:0] t;
      t = ({24'd0, v[31:24]} << 7) | ({24'd0, v[23:16]} << 8) |
          ({24'd0, v[15:8]} << 16) | ({24'd0, v[7:0]} << 24);
      return t >> 7;
    endfunction

    function void note_input(kind_e action, logic [7:0] b);
      logic [31:0] older;
      logic [31:0] newer;
      logic [31:0] x;
      restored_t   tail;
      int          n;
      if (action == KIND_BYTE) begin
        older = window[31:0];
        newer = window[63:32];
        if (position >= skip_mark && (older & OpTopMask) == OpTopCall) begin
          skip_mark = position + 32'd4;
          x = newer - OpBias;
          if (x < OpRange) begin
            x = (swap_operand(x) - position) & OpMask;
            window[63:32] = x + OpBias;
            operands_restored++;
          end
        end
        if (!empty_marks[7]) begin
          restored_q.push_back('{data: window[7:0], valid: 1'b1, last: 1'b0});
        end
        window      = {b, window[63:8]};
        empty_marks = empty_marks << 1;
        position    = position + 32'd1;
      end else begin
        n = 0;
        for (int m = 0; m < 8; m++) begin
          if (!empty_marks[7-m]) begin
            restored_q.push_back('{data: window[8*m +: 8], valid: 1'b1, last: 1'b0});
            n++;
          end
        end
        if (n == 0) begin
          restored_q.push_back('{data: 8'h00, valid: 1'b0, last: 1'b1});
        end else begin
          tail = restored_q.pop_back();
          tail.last = 1'b1;
          restored_q.push_back(tail);
        end
        ends_seen++;
        clear();
      end
    endfunction

    function void flag(string what, restored_t want, restored_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (%s): expected byte %02h valid %0b last %0b,",
                 what, want.data, want.valid, want.last);
        $display("  got byte %02h valid %0b last %0b", got.data, got.valid, got.last);
      end
    endfunction

    function void check_result(logic [7:0] b, logic v, logic l);
      restored_t want;
      restored_t got;
      got = '{data: b, valid: v, last: l};
      if (restored_q.size() == 0) begin
        flag("no word expected", '0, got);
      end else begin
        want = restored_q.pop_front();
        words_checked++;
        if (want.data !== got.data || want.valid !== got.valid || want.last !== got.last) begin
          flag("wrong field", want, got);
        end
      end
    endfunction

    function int pending();
      return restored_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  bit   hold_req;
  int   words_sent;
  restore_board board;

  xcd_in_if  in_if ();
  xcd_out_if out_if ();

  x86_call_address_decoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .data_in_i  (in_if),
    .data_out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_if.ready <= 1'b0;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HoldLen - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) < stall_pct) ? 1'b0 : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      board.check_result(out_if.out_byte, out_if.out_valid, out_if.last);
    end
  end

  task automatic send_word(kind_e action, logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= action;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    board.note_input(action, b);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    int          len;
    int          pick;
    int          i;
    logic [7:0]  top;
    pick = $urandom_range(0, 99);
    len  = (pick < 70) ? $urandom_range(0, 12) :
           (pick < 95) ? $urandom_range(13, 40) : $urandom_range(41, 80);
    i = 0;
    while (i < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_word(KIND_BYTE, $urandom_range(0, 1) ? 8'hE9 : 8'hE8);
        for (int k = 0; k < 3; k++) send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 85) top = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else top = 8'($urandom_range(0, 255));
        send_word(KIND_BYTE, top);
        i += 5;
      end else if (pick < 20) begin
        send_word(KIND_BYTE, $urandom_range(0, 1) ? 8'hE9 : 8'hE8);
        i++;
      end else begin
        send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        i++;
      end
    end
    send_word(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int target;
    logic [7:0] calls_a[12];
    logic [7:0] calls_b[8];
    calls_a = '{8'h00, 8'hE8, 8'h10, 8'h20, 8'h30, 8'hFF,
                8'hE9, 8'h01, 8'h02, 8'h03, 8'h00, 8'hFF};
    calls_b = '{8'hE8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h01};
    in_if.valid   = 1'b0;
    in_if.action  = KIND_BYTE;
    in_if.in_byte = 8'h00;
    rst_n      = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    words_sent = 0;
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(KIND_END, 8'h00);
    send_word(KIND_END, 8'hFF);
    foreach (calls_a[k]) send_word(KIND_BYTE, calls_a[k]);
    send_word(KIND_END, 8'h00);
    foreach (calls_b[k]) send_word(KIND_BYTE, calls_b[k]);
    send_word(KIND_END, 8'h00);
    send_word(KIND_BYTE, 8'h7F);
    send_word(KIND_END, 8'hFF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      target = words_sent + PhaseLen;
      while (words_sent < target) send_stream();
    end
    in_if.valid <= 1'b0;
    stall_pct = 0;

    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d words including %0d end words; %0d result words checked.",
             words_sent, board.ends_seen, board.words_checked);
    $display("Restored %0d call operands under four idle patterns and one long output stall.",
             board.operands_restored);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches in total.", board.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- sim.f -----
src/xcd_pkg.sv
src/xcd_if.sv
src/xcd_front.sv
src/xcd_queue.sv
src/xcd_back.sv
src/x86_call_address_decoder.sv
tb/tb_top.sv
